FILE: sv/h264d_pkg.sv
// Shared types and constants for the H.264 RTP payload depacketizer.
`timescale 1ns / 1ps
`default_nettype none

package h264d_pkg;

    localparam int MAX_PAYLOAD_BYTES = 4096;
    localparam int POS_W = $clog2(MAX_PAYLOAD_BYTES + 1);
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_PAYLOAD_BYTES);
    localparam logic [12:0] UNIT_MAX = 13'h1FFF;
    localparam int RESULTS_MAX = 3;

    // NAL unit types that the block treats specially.
    localparam logic [4:0] NAL_IDR    = 5'd5;
    localparam logic [4:0] NAL_SPS    = 5'd7;
    localparam logic [4:0] NAL_AUD    = 5'd9;
    localparam logic [4:0] NAL_STAP_A = 5'd24;
    localparam logic [4:0] NAL_FU_A   = 5'd28;

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_INFO    = 2'd1,
        KIND_SUMMARY = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        MODE_SINGLE = 2'd0,
        MODE_STAP_A = 2'd1,
        MODE_FU_A   = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        PH_LEN_HI = 2'd0,
        PH_LEN_LO = 2'd1,
        PH_FIRST  = 2'd2,
        PH_BODY   = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_AGG    = 3'd1,
        ST_FRAG_TRUNC = 3'd2,
        ST_NESTED     = 3'd3,
        ST_TOO_LONG   = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       end_of_payload;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  item_kind;
        logic [7:0]  data_out;
        logic [4:0]  unit_type;
        logic [1:0]  packetization;
        logic        key_frame;
        logic        first_in_frame;
        logic [12:0] unit_count;
        logic [2:0]  status;
        logic        run_last;
    } t_out_item;

endpackage

`default_nettype wire

FILE: sv/h264_rtp_payload_depacketizer.sv
// Top level of the H.264 RTP payload depacketizer: byte walk, unit listing and summary.
// A byte accepted into the input register is processed into the result register, from
// which its first result is shown on the output.
// Throughput: one byte per cycle while the output is ready and each byte gives at most
// one result; a byte with up to 3 results holds the result register until all are taken.
// Reset: synchronous, active low; clears all packet state and both valid flags.
`timescale 1ns / 1ps
`default_nettype none

module h264_rtp_payload_depacketizer
    import h264d_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    // Input register.
    logic      r_in_valid;
    t_in_item  r_in;

    // Packet state.
    t_mode            r_mode, n_mode;
    logic [POS_W-1:0] r_pos, n_pos;
    t_phase           r_phase, n_phase;
    logic [7:0]       r_lenhi, n_lenhi;
    logic [15:0]      r_left, n_left;
    t_status          r_err, n_err;
    logic             r_key, n_key;
    logic             r_start, n_start;
    logic [4:0]       r_htype, n_htype;
    logic [12:0]      r_units, n_units;
    logic [2:0]       r_fnri, n_fnri;

    // Result register: the items caused by one byte.
    t_out_item   r_items [RESULTS_MAX];
    t_out_item   n_items [RESULTS_MAX];
    logic        r_bvalid;
    logic [1:0]  r_bcnt, n_bcnt;
    logic [1:0]  r_idx;

    logic        out_take;
    logic        last_take;
    logic        bundle_free;
    logic        move;

    assign o_out_valid = r_bvalid;
    assign o_out_data  = r_items[r_idx];
    assign out_take    = r_bvalid && i_out_ready;
    assign last_take   = out_take && (r_idx == r_bcnt - 2'd1);
    assign bundle_free = !r_bvalid || last_take;
    assign move        = r_in_valid && bundle_free;
    assign o_in_ready  = !r_in_valid || move;

    // Work for one byte: next packet state and up to three result items.
    always_comb begin
        logic [7:0]  b;
        logic [POS_W-1:0] p;
        logic [4:0]  t;
        logic        emit_data;
        logic [7:0]  data_val;
        logic        do_list;
        logic [4:0]  list_t;
        logic        emit_info;
        logic [4:0]  info_t;
        logic        do_count;
        logic [15:0] size;
        logic [15:0] left_dec;
        logic [1:0]  k;
        t_out_item   it;

        b         = r_in.payload_byte;
        p         = r_pos;
        t         = b[4:0];
        emit_data = 1'b0;
        data_val  = b;
        do_list   = 1'b0;
        list_t    = t;
        emit_info = 1'b0;
        info_t    = t;
        do_count  = 1'b0;
        size      = {r_lenhi, b};
        left_dec  = r_left - 16'd1;
        k         = 2'd0;
        it        = '0;

        n_mode  = r_mode;
        n_pos   = r_pos;
        n_phase = r_phase;
        n_lenhi = r_lenhi;
        n_left  = r_left;
        n_err   = r_err;
        n_key   = r_key;
        n_start = r_start;
        n_htype = r_htype;
        n_units = r_units;
        n_fnri  = r_fnri;
        for (int i = 0; i < RESULTS_MAX; i++) begin
            n_items[i] = '0;
        end

        if (p >= MAX_POS) begin
            // Bytes past the length limit are dropped.
            if (r_err == ST_OK) begin
                n_err = ST_TOO_LONG;
            end
        end else begin
            n_pos = p + POS_W'(1);
            if (p == '0) begin
                n_htype = t;
                n_fnri  = b[7:5];
                n_phase = PH_LEN_HI;
                if (t == NAL_FU_A) begin
                    n_mode = MODE_FU_A;
                end else if (t == NAL_STAP_A) begin
                    n_mode = MODE_STAP_A;
                end else begin
                    n_mode = MODE_SINGLE;
                end
                emit_data = (t != NAL_FU_A);
            end else if (r_mode == MODE_SINGLE) begin
                emit_data = 1'b1;
                if (32'(p) == 32'd1) begin
                    do_list = 1'b1;
                    list_t  = r_htype;
                end
            end else if (r_mode == MODE_STAP_A) begin
                emit_data = 1'b1;
                if (r_err == ST_OK) begin
                    case (r_phase)
                        PH_LEN_HI: begin
                            n_lenhi = b;
                            n_phase = PH_LEN_LO;
                        end
                        PH_LEN_LO: begin
                            if (size == 16'd0) begin
                                n_err = ST_BAD_AGG;
                            end else begin
                                n_left  = size;
                                n_phase = PH_FIRST;
                            end
                        end
                        PH_FIRST: begin
                            if (32'(p) == 32'd3) begin
                                n_htype = t;
                            end
                            // Units of a single byte are walked but not listed.
                            do_list = (r_left > 16'd1);
                            n_left  = left_dec;
                            n_phase = (left_dec == 16'd0) ? PH_LEN_HI : PH_BODY;
                        end
                        default: begin
                            if (r_left != 16'd0) begin
                                n_left = left_dec;
                            end
                            if (r_left <= 16'd1) begin
                                n_phase = PH_LEN_HI;
                            end
                        end
                    endcase
                end
            end else if (32'(p) == 32'd1) begin
                // FU header: rebuild the NAL header on a start fragment.
                n_htype = t;
                if (t == NAL_IDR) begin
                    n_key = 1'b1;
                end
                if (b[7]) begin
                    emit_data = 1'b1;
                    data_val  = {r_fnri, t};
                    if (t == NAL_IDR) begin
                        n_start = 1'b1;
                    end
                    do_count  = 1'b1;
                    emit_info = 1'b1;
                    info_t    = t;
                end
            end else begin
                emit_data = 1'b1;
            end
        end

        if (do_list && n_err == ST_OK) begin
            if (list_t == NAL_STAP_A || list_t == NAL_FU_A) begin
                n_err = ST_NESTED;
            end else begin
                if (list_t == NAL_IDR || list_t == NAL_SPS) begin
                    n_key = 1'b1;
                end
                if (list_t >= NAL_IDR && list_t <= NAL_AUD) begin
                    n_start = 1'b1;
                end
                do_count  = 1'b1;
                emit_info = 1'b1;
                info_t    = list_t;
            end
        end

        if (do_count && r_units != UNIT_MAX) begin
            n_units = r_units + 13'd1;
        end

        if (r_in.end_of_payload) begin
            if (n_err == ST_OK && n_mode == MODE_STAP_A &&
                (n_phase == PH_FIRST || n_phase == PH_BODY || 32'(n_pos) < 32'd4)) begin
                n_err = ST_BAD_AGG;
            end
            if (n_err == ST_OK && n_mode == MODE_FU_A && 32'(n_pos) < 32'd2) begin
                n_err = ST_FRAG_TRUNC;
            end
        end

        // Items go out in the order data, info, summary.
        if (emit_data) begin
            it               = '0;
            it.item_kind     = KIND_DATA;
            it.data_out      = data_val;
            it.packetization = n_mode;
            n_items[k]       = it;
            k                = k + 2'd1;
        end
        if (emit_info) begin
            it               = '0;
            it.item_kind     = KIND_INFO;
            it.unit_type     = info_t;
            it.packetization = n_mode;
            n_items[k]       = it;
            k                = k + 2'd1;
        end
        if (r_in.end_of_payload) begin
            it                = '0;
            it.item_kind      = KIND_SUMMARY;
            it.unit_type      = n_htype;
            it.packetization  = n_mode;
            it.key_frame      = n_key;
            it.first_in_frame = n_start;
            it.unit_count     = n_units;
            it.status         = n_err;
            n_items[k]        = it;
            k                 = k + 2'd1;

            // The summary closes the packet: all state returns to its reset values.
            n_mode  = MODE_SINGLE;
            n_pos   = '0;
            n_phase = PH_LEN_HI;
            n_lenhi = '0;
            n_left  = '0;
            n_err   = ST_OK;
            n_key   = 1'b0;
            n_start = 1'b0;
            n_htype = '0;
            n_units = '0;
            n_fnri  = '0;
        end
        if (k != 2'd0) begin
            n_items[k - 2'd1].run_last = 1'b1;
        end
        n_bcnt = k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_SINGLE;
            r_pos    <= '0;
            r_phase  <= PH_LEN_HI;
            r_lenhi  <= '0;
            r_left   <= '0;
            r_err    <= ST_OK;
            r_key    <= 1'b0;
            r_start  <= 1'b0;
            r_htype  <= '0;
            r_units  <= '0;
            r_fnri   <= '0;
            r_bvalid <= 1'b0;
            r_bcnt   <= '0;
            r_idx    <= '0;
        end else if (move) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_phase  <= n_phase;
            r_lenhi  <= n_lenhi;
            r_left   <= n_left;
            r_err    <= n_err;
            r_key    <= n_key;
            r_start  <= n_start;
            r_htype  <= n_htype;
            r_units  <= n_units;
            r_fnri   <= n_fnri;
            r_bvalid <= (n_bcnt != 2'd0);
            r_bcnt   <= n_bcnt;
            r_idx    <= '0;
        end else if (last_take) begin
            r_bvalid <= 1'b0;
        end else if (out_take) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            for (int i = 0; i < RESULTS_MAX; i++) begin
                r_items[i] <= n_items[i];
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/h264d_checker.sv
// Port-level checks for the H.264 RTP payload depacketizer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module h264d_checker
    import h264d_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item i_out_data
);

    // A result that is not taken holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("output transaction changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // The summary always closes the results of its byte.
    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.item_kind == KIND_SUMMARY |-> i_out_data.run_last)
        else $error("summary not marked as last result");

    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.item_kind == KIND_DATA |->
            i_out_data.unit_type == 5'd0 && i_out_data.unit_count == 13'd0 &&
            i_out_data.status == ST_OK && !i_out_data.key_frame &&
            !i_out_data.first_in_frame)
        else $error("data transaction carries summary fields");

    a_nondata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.item_kind != KIND_DATA |-> i_out_data.data_out == 8'd0)
        else $error("non-data transaction carries a data byte");

endmodule

bind h264_rtp_payload_depacketizer h264d_checker u_h264d_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);

`default_nettype wire
